### rtl/kssrm_pkg.sv
package kssrm_pkg;

  // Operation codes carried on the mode field.
  typedef logic [1:0] mode_t;

  localparam mode_t MODE_PUSH   = 2'd0;
  localparam mode_t MODE_REMOVE = 2'd1;
  localparam mode_t MODE_SEARCH = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_OUT
  } kssrm_state_t;

endpackage

### rtl/keyed_stack_search_remove_min_top.sv
// Keyed record stack with search, remove-first-match-from-top and minimum report.
// Input channel (in_valid/in_ready) carries one transaction per operation:
// in_mode selects push, remove or search, in_key is the key and in_payload the
// tag stored by a push. The output channel (out_valid/out_ready) returns exactly
// one transaction per input: hit and overflow flags, the entry count after the
// operation and the minimum key held with its payload (topmost record on ties).
// Records sit in a small one-write, one-read memory with registered read data.
// A single compare unit (equal and less-than against the read key) is stepped
// over the entries under a sequencer, one entry per cycle, in these steps:
//   push   : accept, minimum scan, output
//   search : accept, combined key/minimum scan, output
//   remove : accept, find scan from the top, shift of the records above the
//            match, minimum scan, output; a remove that misses goes to output
//            after the find scan, which also tracks the minimum.
// One operation is in flight at a time: in_ready is high only while idle.
// Reset (synchronous, active low) empties the stack; memory contents are not
// cleared and are never read above the fill count.
// When the receiver stalls, the result holds on the output ports and no new
// transaction is taken until it is accepted.
module keyed_stack_search_remove_min_top #(
  parameter int STACK_DEPTH  = 16,
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  kssrm_pkg::mode_t                  in_mode,
  input  logic [KEY_BITS-1:0]               in_key,
  input  logic [PAYLOAD_BITS-1:0]           in_payload,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic                              out_overflow,
  output logic [$clog2(STACK_DEPTH+1)-1:0]  out_entry_count,
  output logic                              out_min_valid,
  output logic [KEY_BITS-1:0]               out_min_key,
  output logic [PAYLOAD_BITS-1:0]           out_min_payload
);
  import kssrm_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  // Record storage
  logic [KEY_BITS-1:0]     key_mem [STACK_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem [STACK_DEPTH];
  logic [KEY_BITS-1:0]     rd_key_r;
  logic [PAYLOAD_BITS-1:0] rd_pay_r;

  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [KEY_BITS-1:0]     wr_key;
  logic [PAYLOAD_BITS-1:0] wr_pay;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;

  // Sequencer state
  kssrm_state_t state_r, state_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [CNT_W-1:0]        iss_left_r, iss_left_nxt;
  logic [CNT_W-1:0]        src_r, src_nxt;
  logic [CNT_W-1:0]        iss_dec;
  logic                    vld_r, vld_nxt;
  logic [IDX_W-1:0]        rd_idx_r;
  logic                    find_en_r, find_en_nxt;
  logic                    remove_r, remove_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;

  // Result registers
  logic                    hit_r, hit_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    mv_r, mv_nxt;
  logic [KEY_BITS-1:0]     mk_r, mk_nxt;
  logic [PAYLOAD_BITS-1:0] mp_r, mp_nxt;

  // Shared compare unit: read key against search key and running minimum
  logic key_eq;
  logic key_lt;

  assign key_eq  = (rd_key_r == key_r);
  assign key_lt  = (rd_key_r < mk_r);
  assign iss_dec = iss_left_r - 1'b1;

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_pay_r <= pay_mem[rd_addr];
      rd_idx_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      vld_r     <= 1'b0;
      find_en_r <= 1'b0;
      remove_r  <= 1'b0;
      hit_r     <= 1'b0;
      ovf_r     <= 1'b0;
      mv_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      vld_r     <= vld_nxt;
      find_en_r <= find_en_nxt;
      remove_r  <= remove_nxt;
      hit_r     <= hit_nxt;
      ovf_r     <= ovf_nxt;
      mv_r      <= mv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_left_r <= iss_left_nxt;
    src_r      <= src_nxt;
    key_r      <= key_nxt;
    mk_r       <= mk_nxt;
    mp_r       <= mp_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    iss_left_nxt = iss_left_r;
    src_nxt      = src_r;
    vld_nxt      = vld_r;
    find_en_nxt  = find_en_r;
    remove_nxt   = remove_r;
    key_nxt      = key_r;
    hit_nxt      = hit_r;
    ovf_nxt      = ovf_r;
    mv_nxt       = mv_r;
    mk_nxt       = mk_r;
    mp_nxt       = mp_r;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_key       = rd_key_r;
    wr_pay       = rd_pay_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt      = in_key;
          hit_nxt      = 1'b0;
          ovf_nxt      = 1'b0;
          mv_nxt       = 1'b0;
          vld_nxt      = 1'b0;
          find_en_nxt  = 1'b0;
          remove_nxt   = 1'b0;
          iss_left_nxt = fill_r;
          state_nxt    = ST_SCAN;
          unique case (in_mode)
            MODE_PUSH: begin
              // Write the new record on top now; the scan reads it next cycle
              if (fill_r < FULL_CNT) begin
                wr_en        = 1'b1;
                wr_addr      = fill_r[IDX_W-1:0];
                wr_key       = in_key;
                wr_pay       = in_payload;
                fill_nxt     = fill_r + 1'b1;
                iss_left_nxt = fill_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            MODE_REMOVE: begin
              find_en_nxt = 1'b1;
              remove_nxt  = 1'b1;
            end
            MODE_SEARCH: begin
              find_en_nxt = 1'b1;
            end
            default: begin
              // Unused code: report the state only
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue reads from the top down; compare the registered read data in the next cycle
        if (iss_left_r != '0) begin
          rd_en        = 1'b1;
          rd_addr      = iss_dec[IDX_W-1:0];
          iss_left_nxt = iss_dec;
          vld_nxt      = 1'b1;
        end else begin
          vld_nxt = 1'b0;
        end
        if (vld_r) begin
          if (!mv_r || key_lt) begin
            mv_nxt = 1'b1;
            mk_nxt = rd_key_r;
            mp_nxt = rd_pay_r;
          end
        end
        if (vld_r && find_en_r && key_eq) begin
          hit_nxt = 1'b1;
          if (remove_r) begin
            // First match from the top: close the gap above it
            find_en_nxt = 1'b0;
            vld_nxt     = 1'b0;
            src_nxt     = CNT_W'(rd_idx_r) + 1'b1;
            state_nxt   = ST_SHIFT;
          end else if (iss_left_r == '0) begin
            state_nxt = ST_OUT;
          end
        end else if (iss_left_r == '0) begin
          state_nxt = ST_OUT;
        end
      end

      ST_SHIFT: begin
        // Read entry src, write it one place down in the next cycle
        if (src_r < fill_r) begin
          rd_en   = 1'b1;
          rd_addr = src_r[IDX_W-1:0];
          src_nxt = src_r + 1'b1;
          vld_nxt = 1'b1;
        end else begin
          vld_nxt = 1'b0;
        end
        if (vld_r) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_r - 1'b1;
        end
        if (src_r >= fill_r) begin
          fill_nxt     = fill_r - 1'b1;
          iss_left_nxt = fill_r - 1'b1;
          mv_nxt       = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end

      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_hit         = hit_r;
  assign out_overflow    = ovf_r;
  assign out_entry_count = fill_r;
  assign out_min_valid   = mv_r;
  assign out_min_key     = mv_r ? mk_r : '0;
  assign out_min_payload = mv_r ? mp_r : '0;

  // Fill count never passes the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count above stack depth");

  // Overflow is reported only with a full stack
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_entry_count == FULL_CNT)
    else $error("overflow reported with room left");

  // Minimum is valid exactly when records are held
  a_min_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_valid == (out_entry_count != '0))
    else $error("min_valid disagrees with entry count");

  // A push with room grows the stack by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_PUSH && fill_r < FULL_CNT
    |=> fill_r == $past(fill_r) + 1'b1)
    else $error("push did not grow the stack");

  // No new transaction while a result waits
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

endmodule
